@@ hw/rtl/srbmm_pkg.sv @@
// Package for the sample ring buffer with min/max.
// Holds the operation codes, controller states and the item structs.
// No dependencies.
package srbmm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int INDEX_W  = 9;
   localparam int COUNT_W  = 9;

   // Operation codes carried in the op field of a request item
   typedef enum logic [2:0] {
      OP_PUT    = 3'd0,
      OP_NEXT   = 3'd1,
      OP_REWIND = 3'd2,
      OP_INDEX  = 3'd3,
      OP_RECENT = 3'd4,
      OP_CLEAR  = 3'd5,
      OP_MIN    = 3'd6,
      OP_MAX    = 3'd7
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      op_type                      op;
      logic signed [SAMPLE_W-1:0]  sample_in;
      logic [INDEX_W-1:0]          index;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  sample_out;
      logic [COUNT_W-1:0]          valid_count;
   } rsp_type;

endpackage

@@ hw/rtl/srbmm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the sample store; no package dependencies.
module srbmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sample_ring_buffer_min_max.sv @@
// Sample ring buffer with min/max: top level.
// Depends on srbmm_pkg and srbmm_ram.
//
// Usage:
//   Request items (req_data: op, sample_in, index) enter on req_valid and
//   are taken at an edge where req_stall is low. Each item yields exactly
//   one response item (rsp_data: sample_out, valid_count) on rsp_valid,
//   taken at an edge where rsp_stall is low. One item is in flight at a time.
//   Path from accept to response register:
//     put, rewind, empty read-next, out-of-range read-index: loaded directly
//     read-next, read-index, most-recent: via ST_READ (one RAM read)
//     min / max: via ST_SCAN and ST_DRAIN, one RAM read per entry, at least one
//     clear: via ST_SWEEP, one RAM write per entry
//   The single RAM port pair sets these paths. Put sustains one item per cycle
//   when the response side is free; a read takes no new item until it responds.
//   After reset the block sweeps zeros through every entry of the store
//   and holds req_stall high meanwhile. While rsp_stall holds a waiting
//   response, req_stall is high too.
module sample_ring_buffer_min_max
   import srbmm_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Control state
   state_type        state_ff, state_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [AW-1:0]    cursor_ff, cursor_in;
   logic [AW-1:0]    oldest_ff, oldest_in;
   logic [AW-1:0]    last_wr_ff, last_wr_in;
   logic [CW-1:0]    valid_ff, valid_in;
   logic [AW-1:0]    sweep_ff, sweep_in;
   logic             sweep_rsp_ff, sweep_rsp_in;
   logic [SAMPLE_W-1:0] fill_ff, fill_in;
   logic [AW-1:0]    scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic             first_ff, first_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [AW-1:0]    scan_last_ff, scan_last_in;
   logic             is_max_ff, is_max_in;
   logic signed [SAMPLE_W-1:0] best_ff, best_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                ram_we;
   logic [AW-1:0]       ram_wa;
   logic [SAMPLE_W-1:0] ram_wd;
   logic                ram_re;
   logic [AW-1:0]       ram_ra;
   logic [SAMPLE_W-1:0] ram_rd;

   logic                       req_accept;
   logic                       rsp_load;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic signed [SAMPLE_W-1:0] rd_s;
   logic signed [SAMPLE_W-1:0] pick;

   srbmm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   // Running extreme: first entry seeds, later entries replace on strict win
   assign rd_s = $signed(ram_rd);
   always_comb begin
      if (first_ff || (is_max_ff ? (rd_s > best_ff) : (rd_s < best_ff))) begin
         pick = rd_s;
      end else begin
         pick = best_ff;
      end
   end

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      cursor_in    = cursor_ff;
      oldest_in    = oldest_ff;
      last_wr_in   = last_wr_ff;
      valid_in     = valid_ff;
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      first_in     = first_ff;
      scan_last_in = scan_last_ff;
      is_max_in    = is_max_ff;
      best_in      = best_ff;
      ram_we       = 1'b0;
      ram_wa       = sweep_ff;
      ram_wd       = fill_ff;
      ram_re       = 1'b0;
      ram_ra       = scan_ff;
      rsp_load     = 1'b0;
      rsp_sample   = '0;

      unique case (state_ff)
         ST_SWEEP: begin
            ram_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
               rsp_load = sweep_rsp_ff;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.op) inside
                  OP_PUT: begin
                     ram_we     = 1'b1;
                     ram_wa     = wp_ff;
                     ram_wd     = req_data.sample_in;
                     last_wr_in = wp_ff;
                     wp_in      = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
                     if (valid_ff != CW'(DEPTH)) begin
                        valid_in = valid_ff + 1'b1;
                     end
                     if (valid_in == CW'(DEPTH)) begin
                        oldest_in = wp_in;
                     end
                     rsp_load = 1'b1;
                  end
                  OP_NEXT: begin
                     if (valid_ff == '0) begin
                        rsp_load = 1'b1;
                     end else begin
                        ram_re    = 1'b1;
                        ram_ra    = cursor_ff;
                        cursor_in = ((CW'(cursor_ff) + 1'b1) == valid_ff) ? '0
                                    : cursor_ff + 1'b1;
                        state_in  = ST_READ;
                     end
                  end
                  OP_REWIND: begin
                     cursor_in = oldest_ff;
                     rsp_load  = 1'b1;
                  end
                  OP_INDEX: begin
                     if (32'(req_data.index) < DEPTH) begin
                        ram_re   = 1'b1;
                        ram_ra   = AW'(req_data.index);
                        state_in = ST_READ;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  OP_RECENT: begin
                     ram_re   = 1'b1;
                     ram_ra   = last_wr_ff;
                     state_in = ST_READ;
                  end
                  OP_CLEAR: begin
                     fill_in      = req_data.sample_in;
                     sweep_in     = '0;
                     sweep_rsp_in = 1'b1;
                     wp_in        = '0;
                     cursor_in    = '0;
                     oldest_in    = '0;
                     last_wr_in   = '0;
                     valid_in     = '0;
                     state_in     = ST_SWEEP;
                  end
                  OP_MIN, OP_MAX: begin
                     scan_in      = '0;
                     scan_last_in = (valid_ff <= CW'(1)) ? '0 : AW'(valid_ff - CW'(1));
                     is_max_in    = (req_data.op == OP_MAX);
                     first_in     = 1'b1;
                     state_in     = ST_SCAN;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load   = 1'b1;
            rsp_sample = rd_s;
            state_in   = ST_IDLE;
         end
         ST_SCAN: begin
            ram_re  = 1'b1;
            ram_ra  = scan_ff;
            scan_in = scan_ff + 1'b1;
            if (pend_ff) begin
               best_in  = pick;
               first_in = 1'b0;
            end
            if (scan_ff == scan_last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_load   = 1'b1;
            rsp_sample = pick;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      pend_in = (state_ff == ST_SCAN);

      // Response register: loads a new item or holds a stalled one
      rsp_valid_in            = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in             = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.sample_out  = rsp_sample;
         rsp_data_in.valid_count = COUNT_W'(valid_in);
      end
   end

   // State register and control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         wp_ff        <= '0;
         cursor_ff    <= '0;
         oldest_ff    <= '0;
         last_wr_ff   <= '0;
         valid_ff     <= '0;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         fill_ff      <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         cursor_ff    <= cursor_in;
         oldest_ff    <= oldest_in;
         last_wr_ff   <= last_wr_in;
         valid_ff     <= valid_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload flops
   always_ff @(posedge clock) begin
      scan_last_ff <= scan_last_in;
      is_max_ff    <= is_max_in;
      best_ff      <= best_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff <= CW'(DEPTH))
      else $error("valid count exceeds depth");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (valid_ff != '0) |-> (CW'(cursor_ff) < valid_ff))
      else $error("read cursor outside valid entries");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff <= scan_last_ff))
      else $error("scan ran past last entry");

   a_put_counts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.op == OP_PUT) |=> (valid_ff != '0))
      else $error("put left store empty");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.op != OP_PUT && req_data.op != OP_REWIND)
      |=> !rsp_valid_ff || $past(req_data.op == OP_NEXT || req_data.op == OP_INDEX))
      else $error("response appeared too early for a multi-cycle item");

endmodule

@@ tb/sample_ring_buffer_min_max_test.sv @@
`timescale 1ns / 100ps
// Testbench for sample_ring_buffer_min_max: a directed table, then random episodes,
// every response checked against the table's value or an in-bench model of the ring store.
// Depends on srbmm_pkg and the sample_ring_buffer_min_max RTL.
module sample_ring_buffer_min_max_test;
   import srbmm_pkg::*;

   localparam int DEPTH       = 256;
   localparam int RAND_ITEMS  = 1275;
   localparam int MAX_REPORTS = 10;
   // covers the worst item (a min/max or clear over the whole store) plus sender gap
   // and receiver stall, for ~1600 items, then several times over
   localparam int CYCLE_LIMIT = 2000000;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // one row of the directed table; want is used only when typed is set
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // model of the ring store
   logic [SAMPLE_W-1:0] ring_mirror [DEPTH];
   int unsigned wr_ptr;
   int unsigned rd_cursor;
   int unsigned oldest_ptr;
   int unsigned last_ptr;
   int unsigned fill_count;

   rsp_type     expected_q [$];
   rsp_type     head_rsp;
   int unsigned fail_count = 0;
   int unsigned cycle_count;
   int unsigned burst_left;
   int unsigned items_sent;

   sample_ring_buffer_min_max #(
      .DEPTH(DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // fill every entry and reset all pointers (reset and clear)
   function automatic void ring_fill(input logic [SAMPLE_W-1:0] value);
      for (int unsigned i = 0; i < DEPTH; i++)
         ring_mirror[i] = value;
      wr_ptr     = 0;
      rd_cursor  = 0;
      oldest_ptr = 0;
      last_ptr   = 0;
      fill_count = 0;
   endfunction

   // signed min or max over entries 0 .. fill_count-1; entry 0 when empty
   function automatic logic [SAMPLE_W-1:0] ring_extreme(input bit want_max);
      logic signed [SAMPLE_W-1:0] best;
      logic signed [SAMPLE_W-1:0] cand;
      best = ring_mirror[0];
      for (int unsigned i = 1; i < fill_count && i < DEPTH; i++) begin
         cand = ring_mirror[i];
         if (want_max ? (cand > best) : (cand < best))
            best = cand;
      end
      return best;
   endfunction

   // apply one item to the model, return the response it should produce
   function automatic rsp_type ring_apply(input req_type item);
      rsp_type     res;
      int unsigned span;
      res.sample_out = '0;
      case (item.op)
         OP_PUT: begin
            ring_mirror[wr_ptr] = item.sample_in;
            last_ptr = wr_ptr;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            if (fill_count < DEPTH)
               fill_count++;
            // once full, oldest tracks the entry about to be overwritten
            if (fill_count == DEPTH)
               oldest_ptr = wr_ptr;
         end
         OP_NEXT: begin
            // empty store: zero out, cursor stays
            if (fill_count != 0) begin
               span = (fill_count >= DEPTH) ? DEPTH : fill_count;
               res.sample_out = ring_mirror[rd_cursor];
               rd_cursor = (rd_cursor + 1) % span;
            end
         end
         OP_REWIND: rd_cursor = oldest_ptr;
         OP_INDEX: begin
            if (item.index < DEPTH)
               res.sample_out = ring_mirror[item.index];
         end
         OP_RECENT: res.sample_out = ring_mirror[last_ptr];
         OP_CLEAR:  ring_fill(item.sample_in);
         OP_MIN:    res.sample_out = ring_extreme(1'b0);
         OP_MAX:    res.sample_out = ring_extreme(1'b1);
      endcase
      res.valid_count = fill_count[COUNT_W-1:0];
      return res;
   endfunction

   function automatic dir_row_type dir_row(input op_type op, input logic [SAMPLE_W-1:0] sample,
                                           input logic [INDEX_W-1:0] idx, input logic typed,
                                           input logic [SAMPLE_W-1:0] out,
                                           input logic [COUNT_W-1:0] cnt);
      dir_row_type row;
      row.item.op           = op;
      row.item.sample_in    = sample;
      row.item.index        = idx;
      row.typed             = typed;
      row.want.sample_out   = out;
      row.want.valid_count  = cnt;
      return row;
   endfunction

   // mostly full-range random, with the signed extremes and values near zero
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 64) - 32;
         3: return {16'($urandom), 16'h0000};
         default: return $urandom;
      endcase
   endfunction

   // mostly in range, one in five at or above DEPTH
   function automatic logic [INDEX_W-1:0] rand_index();
      if ($urandom_range(0, 4) == 0)
         return INDEX_W'($urandom_range(DEPTH, 511));
      return INDEX_W'($urandom_range(0, DEPTH - 1));
   endfunction

   // present one item in bursts with random gaps; returns the model's response
   task automatic send_item(input req_type item, output rsp_type predicted);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = ring_apply(item);
   endtask

   task automatic send_op(input op_type op, input logic [SAMPLE_W-1:0] sample,
                          input logic [INDEX_W-1:0] idx);
      req_type item;
      rsp_type predicted;
      item.op        = op;
      item.sample_in = sample;
      item.index     = idx;
      send_item(item, predicted);
      expected_q.push_back(predicted);
      items_sent++;
   endtask

   // hold off the sender until every outstanding response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0)
         @(posedge clock);
   endtask

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("unexpected response: sample_out %h valid_count %0d",
                        rsp_data.sample_out, rsp_data.valid_count);
            fail_count++;
         end else begin
            head_rsp = expected_q.pop_front();
            if (rsp_data.sample_out !== head_rsp.sample_out ||
                rsp_data.valid_count !== head_rsp.valid_count) begin
               if (fail_count < MAX_REPORTS)
                  $display("mismatch: sample_out exp %h got %h, valid_count exp %0d got %0d",
                           head_rsp.sample_out, rsp_data.sample_out,
                           head_rsp.valid_count, rsp_data.valid_count);
               fail_count++;
            end
         end
      end
   end

   // receiver stall pattern, in randomly chosen modes held for random stretches
   initial begin
      stall_mode_type mode;
      int unsigned    mode_left;
      int unsigned    period;
      int unsigned    duty;
      int unsigned    phase;
      rsp_stall <= 1'b0;
      mode      = STALL_NONE;
      mode_left = 0;
      period    = 2;
      duty      = 1;
      phase     = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 400);
            period    = $urandom_range(2, 9);
            duty      = $urandom_range(1, period - 1);
         end
         mode_left--;
         phase = (phase + 1) % period;
         case (mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (phase < duty);
         endcase
      end
   end

   // timeout
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sample_ring_buffer_min_max test failed");
      $finish;
   end

   // stimulus
   initial begin
      dir_row_type dir_table [$];
      rsp_type     predicted;
      op_type      op;
      int unsigned kind;
      int unsigned pick;
      int unsigned span;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      ring_fill('0);
      burst_left = 0;
      items_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty store, signed extremes, cursor walk, out-of-range index, clear
      dir_table.push_back(dir_row(OP_MIN,    32'h0,         9'd0,   1'b1, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_MAX,    32'h0,         9'd0,   1'b1, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_NEXT,   32'h0,         9'd0,   1'b1, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_RECENT, 32'h0,         9'd0,   1'b1, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_INDEX,  32'h0,         9'd511, 1'b1, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_PUT,    32'h7FFF_FFFF, 9'd0,   1'b1, 32'h0,         9'd1));
      dir_table.push_back(dir_row(OP_MIN,    32'h0,         9'd0,   1'b1, 32'h7FFF_FFFF, 9'd1));
      dir_table.push_back(dir_row(OP_PUT,    32'h8000_0000, 9'd0,   1'b1, 32'h0,         9'd2));
      dir_table.push_back(dir_row(OP_PUT,    32'h0001_0000, 9'd0,   1'b1, 32'h0,         9'd3));
      dir_table.push_back(dir_row(OP_PUT,    32'hFFFF_0000, 9'd0,   1'b1, 32'h0,         9'd4));
      dir_table.push_back(dir_row(OP_MIN,    32'h0,         9'd0,   1'b1, 32'h8000_0000, 9'd4));
      dir_table.push_back(dir_row(OP_MAX,    32'h0,         9'd0,   1'b1, 32'h7FFF_FFFF, 9'd4));
      dir_table.push_back(dir_row(OP_RECENT, 32'h0,         9'd0,   1'b0, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_NEXT,   32'h0,         9'd0,   1'b0, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_NEXT,   32'h0,         9'd0,   1'b0, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_REWIND, 32'h0,         9'd0,   1'b0, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_NEXT,   32'h0,         9'd0,   1'b0, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_INDEX,  32'h0,         9'd3,   1'b0, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_INDEX,  32'h0,         9'd256, 1'b1, 32'h0,         9'd4));
      dir_table.push_back(dir_row(OP_INDEX,  32'h0,         9'd255, 1'b0, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_CLEAR,  32'h5A5A_5A5A, 9'd0,   1'b1, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_INDEX,  32'h0,         9'd200, 1'b0, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_RECENT, 32'h0,         9'd0,   1'b0, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_NEXT,   32'h0,         9'd0,   1'b1, 32'h0,         9'd0));
      dir_table.push_back(dir_row(OP_MAX,    32'h0,         9'd0,   1'b0, 32'h0,         9'd0));

      foreach (dir_table[i]) begin
         send_item(dir_table[i].item, predicted);
         expected_q.push_back(dir_table[i].typed ? dir_table[i].want : predicted);
      end
      wait_drained();

      // wrap the store early so full-store pointer handling is exercised
      repeat (DEPTH + $urandom_range(1, 40))
         send_op(OP_PUT, pick_sample(), rand_index());

      // random episodes: put bursts, read mixes, min/max, clears, noise
      while (items_sent < RAND_ITEMS) begin
         if ($urandom_range(0, 9) == 0)
            wait_drained();
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            span = ($urandom_range(0, 4) == 0) ? $urandom_range(64, 320) : $urandom_range(1, 64);
            repeat (span)
               send_op(OP_PUT, pick_sample(), rand_index());
         end else if (kind < 65) begin
            repeat ($urandom_range(1, 40)) begin
               pick = $urandom_range(0, 19);
               if (pick < 8)
                  op = OP_NEXT;
               else if (pick < 10)
                  op = OP_REWIND;
               else if (pick < 15)
                  op = OP_INDEX;
               else if (pick < 18)
                  op = OP_RECENT;
               else
                  op = OP_PUT;
               send_op(op, pick_sample(), rand_index());
            end
         end else if (kind < 80) begin
            send_op(($urandom_range(0, 1) != 0) ? OP_MAX : OP_MIN, pick_sample(), rand_index());
         end else if (kind < 86) begin
            send_op(OP_CLEAR, pick_sample(), rand_index());
         end else begin
            repeat ($urandom_range(1, 10))
               send_op(op_type'($urandom_range(0, 7)), $urandom,
                       INDEX_W'($urandom_range(0, 511)));
         end
      end

      wait_drained();
      repeat (DEPTH + 8) @(posedge clock);
      if (fail_count == 0 && expected_q.size() == 0)
         $display("sample_ring_buffer_min_max test passed");
      else
         $display("sample_ring_buffer_min_max test failed");
      $finish;
   end

endmodule
